// File: hw/rtl/char_lcd_nibble_writer_assert.svh
// assertion macros for the character lcd nibble writer
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CLN_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("char lcd writer: assertion failed");
`define CLN_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("char lcd writer: assertion failed");
`else
`define CLN_ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define CLN_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// File: hw/rtl/cln_pkg.sv
// shared types, constants and tables of the character lcd nibble writer
package cln_pkg;

    localparam int Columns = 16;
    localparam int Rows    = 2;

    localparam int TickW = 20;
    localparam int HoldW = 21;

    localparam logic [2:0] KindInit   = 3'd0;
    localparam logic [2:0] KindCmd    = 3'd1;
    localparam logic [2:0] KindData   = 3'd2;
    localparam logic [2:0] KindCursor = 3'd3;
    localparam logic [2:0] KindClear  = 3'd4;
    localparam logic [2:0] KindMode   = 3'd5;

    localparam logic [1:0] CfgStrobe  = 2'd0;
    localparam logic [1:0] CfgSettle  = 2'd1;
    localparam logic [1:0] CfgPowerUp = 2'd2;

    localparam logic [7:0] CmdFunctionSet = 8'h28;
    localparam logic [7:0] CmdEntryMode   = 8'h06;
    localparam logic [7:0] CmdDisplayOn   = 8'h0C;
    localparam logic [7:0] CmdClear       = 8'h01;
    localparam logic [7:0] CmdSetAddress  = 8'h80;

    // pause, four wake-up pulses, four setup bytes
    localparam int InitSteps = 25;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [7:0] column;
        logic [7:0] row;
        logic [1:0] display_mode;
    } t_in;

    typedef struct packed {
        logic             reg_select;
        logic             enable_level;
        logic [3:0]       data_nibble;
        logic [HoldW-1:0] hold_ticks;
        logic             last;
    } t_out;

    // one job for the sequencer
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
        logic       settle;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

    function automatic logic [7:0] mode_cmd(input logic [1:0] mode);
        logic [7:0] c;
        case (mode)
            2'd0:    c = 8'h08;
            2'd1:    c = CmdDisplayOn;
            2'd2:    c = 8'h0E;
            default: c = 8'h0F;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CmdFunctionSet;
            2'd1:    c = CmdEntryMode;
            2'd2:    c = CmdDisplayOn;
            default: c = CmdClear;
        endcase
        return c;
    endfunction

    // nibble of the given enable pulse within init, pulses counted from zero
    function automatic logic [3:0] init_nibble(input logic [3:0] pulse_idx);
        logic [3:0] n;
        logic [3:0] off;
        logic [7:0] b;
        off = pulse_idx - 4'd4;
        b   = init_byte(off[2:1]);
        if (pulse_idx < 4'd3) begin
            n = 4'h3;
        end else if (pulse_idx == 4'd3) begin
            n = 4'h2;
        end else if (off[0]) begin
            n = b[3:0];
        end else begin
            n = b[7:4];
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/cln_front.sv
// front end: takes requests, turns them into byte jobs and queues them
module cln_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  cln_pkg::t_in     i_in,
    output logic             full,
    output cln_pkg::t_job_chan o_job,
    input  logic             i_job_take
);
    import cln_pkg::*;

    t_job       w_job;
    logic       w_job_ok;
    logic [7:0] w_col;
    logic [7:0] w_row;
    logic       w_wr;
    logic       w_rd;

    t_job       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_cnt;

    always_comb begin
        w_col = (i_in.column >= 8'(Columns)) ? 8'd0 : i_in.column;
        w_row = (i_in.row >= 8'(Rows)) ? 8'd0 : i_in.row;
        w_job_ok = 1'b1;
        w_job = '{is_init: 1'b0, rs: 1'b0, value: i_in.byte_value, settle: 1'b0};
        case (i_in.kind)
            KindInit: begin
                w_job.is_init = 1'b1;
            end
            KindCmd: begin
                w_job.rs = 1'b0;
            end
            KindData: begin
                w_job.rs = 1'b1;
            end
            KindCursor: begin
                w_job.value = CmdSetAddress | (w_row << 6) | w_col;
            end
            KindClear: begin
                w_job.value  = CmdClear;
                w_job.settle = 1'b1;
            end
            KindMode: begin
                w_job.value = mode_cmd(i_in.display_mode);
            end
            default: begin
                // unused kinds are taken and dropped
                w_job_ok = 1'b0;
            end
        endcase
    end

    assign full  = (r_cnt == 2'd2);
    assign w_wr  = push && !full && w_job_ok;
    assign w_rd  = i_job_take && (r_cnt != 2'd0);

    assign o_job.valid = (r_cnt != 2'd0);
    assign o_job.job   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

// File: hw/rtl/cln_back.sv
// back end: steps through the pin states of each job into a small result queue
module cln_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cln_pkg::t_job_chan        i_job,
    output logic                      o_job_take,
    input  logic [cln_pkg::TickW-1:0] i_strobe_ticks,
    input  logic [cln_pkg::TickW-1:0] i_settle_ticks,
    input  logic [cln_pkg::TickW-1:0] i_power_up_ticks,
    output logic                      empty,
    input  logic                      pop,
    output cln_pkg::t_out             o_out
);
    import cln_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [4:0] r_step;
    logic       n_busy;
    logic [4:0] n_step;

    t_out       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    t_out       w_pin;
    logic       w_settle;
    logic [4:0] w_p;
    logic [3:0] w_pulse;
    logic       w_pop;
    logic       w_room;
    logic       w_emit;
    logic       w_load;

    // pin state for the current step
    always_comb begin
        w_p     = r_step - 5'd1;
        w_pulse = w_p[4:1];
        w_pin.reg_select = r_job.rs;
        if (r_job.is_init) begin
            w_pin.enable_level = ~w_p[0];
            w_pin.data_nibble  = init_nibble(w_pulse);
            w_settle = (w_pulse < 4'd4) || (w_pulse == 4'd11);
            w_pin.last = (r_step == 5'(InitSteps - 1));
        end else begin
            w_pin.enable_level = ~r_step[0];
            w_pin.data_nibble  = r_step[1] ? r_job.value[3:0] : r_job.value[7:4];
            w_settle   = r_job.settle && r_step[1];
            w_pin.last = (r_step[1:0] == 2'd3);
        end
        if (w_pin.enable_level) begin
            w_pin.hold_ticks = {1'b0, i_strobe_ticks};
        end else begin
            w_pin.hold_ticks = {1'b0, i_strobe_ticks}
                + (w_settle ? {1'b0, i_settle_ticks} : {HoldW{1'b0}});
        end
        // opening pause of init, all pins low
        if (r_job.is_init && (r_step == 5'd0)) begin
            w_pin.reg_select   = 1'b0;
            w_pin.enable_level = 1'b0;
            w_pin.data_nibble  = 4'h0;
            w_pin.hold_ticks   = {1'b0, i_power_up_ticks};
        end
    end

    assign empty  = (r_cnt == 2'd0);
    assign w_pop  = pop && !empty;
    assign w_room = (r_cnt != 2'd2) || w_pop;
    assign w_emit = r_busy && w_room;
    assign w_load = i_job.valid && (!r_busy || (w_emit && w_pin.last));
    assign o_job_take = w_load;
    assign o_out  = r_buf[r_rd_ptr];

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_load) begin
            n_busy = 1'b1;
            n_step = 5'd0;
        end else if (w_emit) begin
            n_busy = !w_pin.last;
            n_step = r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= 5'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_wr_ptr <= w_emit ? ~r_wr_ptr : r_wr_ptr;
            r_rd_ptr <= w_pop ? ~r_rd_ptr : r_rd_ptr;
            r_cnt    <= r_cnt + {1'b0, w_emit} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job.job;
        end
        if (w_emit) begin
            r_buf[r_wr_ptr] <= w_pin;
        end
    end

endmodule

// File: hw/rtl/char_lcd_nibble_writer.sv
// top level of the character lcd 4-bit nibble writer
// Requests go in through a push/full queue port and come out as pin states
// (register select, enable, D7..D4, hold time, last flag) through an
// empty/pop queue port, oldest first. A byte request (command, data, set
// cursor, clear, display mode) gives four pin states, an init request 25,
// and an unused kind is taken with no result. The back-end sequencer makes
// one pin state per clock while the result queue has room; a two-job queue
// in front and a two-beat result queue behind let requests arrive and
// results leave at their own pace. The three timing registers are written
// through the cfg port, which is always ready; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module char_lcd_nibble_writer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  cln_pkg::t_in              i_in,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output cln_pkg::t_out             o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [cln_pkg::TickW-1:0] i_cfg_data
);
    import cln_pkg::*;

`include "char_lcd_nibble_writer_assert.svh"

    logic [TickW-1:0] r_strobe_ticks;
    logic [TickW-1:0] r_settle_ticks;
    logic [TickW-1:0] r_power_up_ticks;

    t_job_chan w_job;
    logic      w_job_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe_ticks   <= TickW'(100);
            r_settle_ticks   <= TickW'(50000);
            r_power_up_ticks <= TickW'(500000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgStrobe:  r_strobe_ticks   <= i_cfg_data;
                CfgSettle:  r_settle_ticks   <= i_cfg_data;
                CfgPowerUp: r_power_up_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cln_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in       (i_in),
        .full       (full),
        .o_job      (w_job),
        .i_job_take (w_job_take)
    );

    cln_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (w_job),
        .o_job_take       (w_job_take),
        .i_strobe_ticks   (r_strobe_ticks),
        .i_settle_ticks   (r_settle_ticks),
        .i_power_up_ticks (r_power_up_ticks),
        .empty            (empty),
        .pop              (pop),
        .o_out            (o_out)
    );

    // a job is only taken when one is queued
    `CLN_ASSERT_HOLDS(a_take_needs_job, i_clk, i_rst_n, !w_job_take || w_job.valid)
    // an empty job queue never reports full
    `CLN_ASSERT_HOLDS(a_full_needs_jobs, i_clk, i_rst_n, w_job.valid || !full)
    // a waiting beat that is not popped stays waiting
    `CLN_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, !empty && !pop, !empty)

endmodule

// File: verif/tb.sv
// self-checking testbench for the character lcd nibble writer
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cln_pkg::*;

    // kinds the block takes without any pin state
    localparam logic [2:0] KindSpareA = 3'd6;
    localparam logic [2:0] KindSpareB = 3'd7;

    localparam logic [3:0] WakeNibble    = 4'h3;
    localparam logic [3:0] FourBitNibble = 4'h2;
    localparam logic [7:0] ModeBytes [4] = '{8'h08, 8'h0C, 8'h0E, 8'h0F};

    localparam logic [TickW-1:0] TickMax = '1;

    localparam int QuietLimit  = 5000;
    localparam int DrainCycles = 64;
    localparam int StallCycles = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    t_in                req_in = '0;
    logic               full;
    logic               empty;
    logic               pop = 1'b0;
    t_out               pin_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [TickW-1:0]   cfg_data = '0;

    // timing registers as the block should hold them
    logic [TickW-1:0]   strobe_ticks = 20'd100;
    logic [TickW-1:0]   settle_ticks = 20'd50000;
    logic [TickW-1:0]   power_up_ticks = 20'd500000;

    t_out               pending_pins [$];
    t_out               req_pins [$];

    int                 errors = 0;
    int                 send_idle_pct = 23;
    int                 recv_idle_pct = 83;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;
    logic               stall_tog = 1'b0;
    logic               stall_seen = 1'b0;

    char_lcd_nibble_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (req_in),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_out       (pin_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic add_pin(input logic rs, input logic en, input logic [3:0] nib,
                           input logic [HoldW-1:0] hold);
        t_out p;
        p.reg_select   = rs;
        p.enable_level = en;
        p.data_nibble  = nib;
        p.hold_ticks   = hold;
        p.last         = 1'b0;
        req_pins.push_back(p);
    endtask

    task automatic add_pulse(input logic rs, input logic [3:0] nib, input bit settle);
        logic [HoldW-1:0] low_hold;
        low_hold = {1'b0, strobe_ticks} + (settle ? {1'b0, settle_ticks} : '0);
        add_pin(rs, 1'b1, nib, {1'b0, strobe_ticks});
        add_pin(rs, 1'b0, nib, low_hold);
    endtask

    task automatic add_byte(input logic rs, input logic [7:0] b, input bit settle);
        add_pulse(rs, b[7:4], 1'b0);
        add_pulse(rs, b[3:0], settle);
    endtask

    task automatic predict_pins(input t_in req);
        logic [7:0] col;
        logic [7:0] line;
        t_out       p;
        req_pins.delete();
        case (req.kind)
            KindInit: begin
                add_pin(1'b0, 1'b0, 4'h0, {1'b0, power_up_ticks});
                repeat (3) add_pulse(1'b0, WakeNibble, 1'b1);
                add_pulse(1'b0, FourBitNibble, 1'b1);
                add_byte(1'b0, CmdFunctionSet, 1'b0);
                add_byte(1'b0, CmdEntryMode, 1'b0);
                add_byte(1'b0, CmdDisplayOn, 1'b0);
                add_byte(1'b0, CmdClear, 1'b1);
            end
            KindCmd:   add_byte(1'b0, req.byte_value, 1'b0);
            KindData:  add_byte(1'b1, req.byte_value, 1'b0);
            KindCursor: begin
                col  = (req.column >= Columns) ? 8'd0 : req.column;
                line = (req.row >= Rows) ? 8'd0 : req.row;
                add_byte(1'b0, CmdSetAddress | (line << 6) | col, 1'b0);
            end
            KindClear: add_byte(1'b0, CmdClear, 1'b1);
            KindMode:  add_byte(1'b0, ModeBytes[req.display_mode], 1'b0);
            default: ;
        endcase
        if (req_pins.size() > 0) begin
            p = req_pins[req_pins.size() - 1];
            p.last = 1'b1;
            req_pins[req_pins.size() - 1] = p;
        end
        foreach (req_pins[i]) pending_pins.push_back(req_pins[i]);
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_tog != stall_seen) begin
            stall_seen <= stall_tog;
            stall_left <= StallCycles;
            pop        <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(input string name, input logic [HoldW-1:0] want,
                                input logic [HoldW-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : pin_check
        t_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_pins.size() == 0) begin
                errors++;
                $display("%0t: pin state with nothing expected, expected none, got %p",
                         $time, pin_out);
            end else begin
                want = pending_pins.pop_front();
                if (pin_out.reg_select !== want.reg_select)
                    report_field("reg_select", want.reg_select, pin_out.reg_select);
                if (pin_out.enable_level !== want.enable_level)
                    report_field("enable_level", want.enable_level, pin_out.enable_level);
                if (pin_out.data_nibble !== want.data_nibble)
                    report_field("data_nibble", want.data_nibble, pin_out.data_nibble);
                if (pin_out.hold_ticks !== want.hold_ticks)
                    report_field("hold_ticks", want.hold_ticks, pin_out.hold_ticks);
                if (pin_out.last !== want.last)
                    report_field("last", want.last, pin_out.last);
            end
        end
    end

    // any accepted beat on any port resets the count
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- request side

    task automatic send_req(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        req_in <= req;
        do @(posedge i_clk); while (full !== 1'b0);
        predict_pins(req);
    endtask

    // push stays high after a beat, so it is dropped here before any pause
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TickW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        case (idx)
            CfgStrobe:  strobe_ticks   = value;
            CfgSettle:  settle_ticks   = value;
            CfgPowerUp: power_up_ticks = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [TickW-1:0] strobe, input logic [TickW-1:0] settle,
                              input logic [TickW-1:0] power_up);
        wait_idle();
        write_reg(CfgStrobe, strobe);
        write_reg(CfgSettle, settle);
        write_reg(CfgPowerUp, power_up);
    endtask

    function automatic t_in make_req(input logic [2:0] kind, input logic [7:0] b,
                                     input logic [7:0] col, input logic [7:0] line,
                                     input logic [1:0] mode);
        t_in r;
        r.kind         = kind;
        r.byte_value   = b;
        r.column       = col;
        r.row          = line;
        r.display_mode = mode;
        return r;
    endfunction

    function automatic logic [TickW-1:0] pick_ticks();
        logic [TickW-1:0] v;
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = TickMax;
            2:       v = TickW'($urandom_range(1000));
            default: v = TickW'($urandom);
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_timing();
        send_req(make_req(KindInit, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindCmd, 8'h00, 8'hFF, 8'hFF, 2'd3));
        send_req(make_req(KindCmd, 8'hFF, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindData, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindData, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        // last column and row, then just past them, then the top of the range
        send_req(make_req(KindCursor, 8'h00, 8'(Columns - 1), 8'(Rows - 1), 2'd0));
        send_req(make_req(KindCursor, 8'hFF, 8'(Columns), 8'(Rows), 2'd3));
        send_req(make_req(KindCursor, 8'h00, 8'hFF, 8'hFF, 2'd0));
        send_req(make_req(KindCursor, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindClear, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        for (int m = 0; m < 4; m++)
            send_req(make_req(KindMode, 8'h00, 8'h00, 8'h00, 2'(m)));
        send_req(make_req(KindSpareA, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        send_req(make_req(KindSpareB, 8'h00, 8'h00, 8'h00, 2'd0));
    endtask

    task automatic test_timing_extremes();
        set_timing('0, '0, '0);
        send_req(make_req(KindInit, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindClear, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindCmd, 8'hA5, 8'h00, 8'h00, 2'd0));
        set_timing(TickMax, TickMax, TickMax);
        send_req(make_req(KindInit, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindClear, 8'h00, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindData, 8'h5A, 8'h00, 8'h00, 2'd0));
        send_req(make_req(KindCursor, 8'h00, 8'd7, 8'd1, 2'd0));
    endtask

    task automatic test_random_traffic(input int s_idle, input int r_idle, input int count);
        int       sent;
        int       pick;
        t_in      req;
        sent = 0;
        set_timing(pick_ticks(), pick_ticks(), pick_ticks());
        send_idle_pct <= s_idle;
        recv_idle_pct <= r_idle;
        while (sent < count) begin
            pick = $urandom_range(99);
            req.byte_value   = 8'($urandom);
            req.column       = $urandom_range(1) ? 8'($urandom_range(Columns - 1))
                                                 : 8'($urandom);
            req.row          = $urandom_range(1) ? 8'($urandom_range(Rows - 1))
                                                 : 8'($urandom);
            req.display_mode = 2'($urandom);
            if (pick < 4)
                req.kind = KindInit;
            else if (pick < 9)
                req.kind = $urandom_range(1) ? KindSpareA : KindSpareB;
            else
                req.kind = 3'($urandom_range(KindCmd, KindMode));
            send_req(req);
            if (req.kind <= KindMode) sent++;
        end
    endtask

    // receiver holds off while requests keep coming, so the block fills
    task automatic test_queue_full_stall();
        wait_idle();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        stall_tog     <= ~stall_tog;
        for (int i = 0; i < 20; i++)
            send_req(make_req(3'($urandom_range(KindCmd, KindMode)), 8'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom)));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_timing();
        test_timing_extremes();
        test_random_traffic(23, 83, 130);
        test_random_traffic(83, 23, 130);
        test_random_traffic(0, 0, 130);
        test_queue_full_stall();
        wait_idle();
        if (errors == 0 && pending_pins.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cln_pkg.sv
hw/rtl/cln_front.sv
hw/rtl/cln_back.sv
hw/rtl/char_lcd_nibble_writer.sv
verif/tb.sv
